// ----- rtl/sfdc_pkg.sv -----
// Types, constants and the tanh knot table shared by the deadzone controller.
package sfdc_pkg;

	localparam int TANH_SEGMENTS = 32;
	localparam int TANH_IDX_W = $clog2(TANH_SEGMENTS);
	localparam int TANH_X_W = 18;
	localparam int TANH_SCALED_W = TANH_X_W + TANH_IDX_W;
	localparam longint unsigned TANH_SPAN = 64'd262144;
	localparam longint unsigned Q30_ONE = 64'd1073741824;

	localparam logic [18:0] WIN_LOW_EXCL = 19'd102943;
	localparam logic [18:0] WIN_HIGH_EXCL = 19'd308832;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_CART_POS_GAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEND_ANG_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CART_SPD_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PEND_SPD_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_OFS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CART_DEADBAND = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_DEADBAND = 3'd6;

	typedef struct packed {
		logic signed [31:0] cart_pos;
		logic signed [31:0] cart_vel;
		logic signed [31:0] pend_ang;
		logic signed [31:0] pend_vel;
		logic [18:0] reduced_angle;
		logic signed [31:0] cart_target;
		logic signed [31:0] angle_target;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] drive_voltage;
		logic active;
	} out_beat_t;

	typedef logic [TANH_SEGMENTS:0][15:0] tanh_tbl_t;

	// Restoring division, used only while the knot table is built.
	function automatic longint unsigned udiv(longint unsigned n, longint unsigned dv);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int k = 63; k >= 0; k--) begin
			r = (r << 1) | ((n >> k) & 64'd1);
			if (r >= dv) begin
				r = r - dv;
				q = q | (64'd1 << k);
			end
		end
		return q;
	endfunction

	function automatic logic [15:0] tanh_knot(int i);
		longint unsigned x, a, b, b2, b3, b4, y, num, den, r;
		x = (longint'(i) * TANH_SPAN) / TANH_SEGMENTS;
		a = (2 * x) << 14;
		b = a >> 8;
		b2 = (b * b) >> 30;
		b3 = (b2 * b) >> 30;
		b4 = (b3 * b) >> 30;
		y = Q30_ONE - b + b2 / 2 - b3 / 6 + b4 / 24;
		if (y > Q30_ONE) begin
			y = Q30_ONE;
		end
		for (int k = 0; k < 8; k++) begin
			y = (y * y) >> 30;
		end
		num = (Q30_ONE - y) << 16;
		den = Q30_ONE + y;
		r = udiv(num + (den >> 1), den);
		if (r > 64'd65535) begin
			r = 64'd65535;
		end
		return r[15:0];
	endfunction

	function automatic tanh_tbl_t tanh_table();
		tanh_tbl_t t;
		for (int i = 0; i <= TANH_SEGMENTS; i++) begin
			t[i] = tanh_knot(i);
		end
		return t;
	endfunction

	localparam tanh_tbl_t TANH_KNOTS = tanh_table();

endpackage

// ----- rtl/state_feedback_deadzone_controller.sv -----
// Top level of the pipelined state-feedback controller with deadzone compensation.

// Every beat passes seven register stages on its way to the output, and the pipeline
// accepts one beat per clock unless a stalled output has filled every stage; the depth
// comes from the gain multipliers, the tanh interpolation multiplier and the final
// cart-term multiplier, each followed by a register. A stalled output holds only the
// stages behind it that are full, so empty stages keep taking beats. Outside the angle
// window the result is zero with active low. Configuration writes take effect at
// once and are meant to happen while the pipeline is empty.
module state_feedback_deadzone_controller (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sfdc_pkg::in_beat_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output sfdc_pkg::out_beat_t out_data,
	input  logic cfg_wr_en,
	input  logic [sfdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);

	logic signed [31:0] cpg_q, pag_q, csg_q, psg_q;
	logic [30:0] dzo_q, cdb_q, adb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpg_q <= 32'sd29309;
			pag_q <= 32'sd1319341;
			csg_q <= 32'sd3815;
			psg_q <= -32'sd34709;
			dzo_q <= 31'd49152;
			cdb_q <= 31'd13107;
			adb_q <= 31'd3431;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sfdc_pkg::REG_CART_POS_GAIN: cpg_q <= cfg_data;
				sfdc_pkg::REG_PEND_ANG_GAIN: pag_q <= cfg_data;
				sfdc_pkg::REG_CART_SPD_GAIN: csg_q <= cfg_data;
				sfdc_pkg::REG_PEND_SPD_GAIN: psg_q <= cfg_data;
				sfdc_pkg::REG_DEADZONE_OFS: dzo_q <= cfg_data[30:0];
				sfdc_pkg::REG_CART_DEADBAND: cdb_q <= cfg_data[30:0];
				sfdc_pkg::REG_ANGLE_DEADBAND: adb_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Stage enables: a stage loads when it is empty or the stage after it moves.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !v_s7 || out_ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// Stage 1: errors, negated speeds and the angle window.
	logic signed [32:0] e_d, ea_d, ncv_d, npv_d;
	logic act_d;
	logic signed [32:0] e_s1, ea_s1, ncv_s1, npv_s1;
	logic act_s1;

	assign e_d = {in_data.cart_target[31], in_data.cart_target}
		- {in_data.cart_pos[31], in_data.cart_pos};
	assign ea_d = {in_data.angle_target[31], in_data.angle_target}
		- {in_data.pend_ang[31], in_data.pend_ang};
	assign ncv_d = 33'sd0 - {in_data.cart_vel[31], in_data.cart_vel};
	assign npv_d = 33'sd0 - {in_data.pend_vel[31], in_data.pend_vel};
	assign act_d = (in_data.reduced_angle > sfdc_pkg::WIN_LOW_EXCL)
		&& (in_data.reduced_angle < sfdc_pkg::WIN_HIGH_EXCL);

	always_ff @(posedge clk) begin
		if (en1) begin
			e_s1 <= e_d;
			ea_s1 <= ea_d;
			ncv_s1 <= ncv_d;
			npv_s1 <= npv_d;
			act_s1 <= act_d;
		end
	end

	// Stage 2: gain products, deadband tests and the tanh argument.
	logic signed [64:0] pc_d, pa_d, pcv_d, ppv_d;
	logic [32:0] mag_c, mag_a;
	logic cart_on_d, ang_on_d, inr_d;
	logic [sfdc_pkg::TANH_X_W-1:0] x_d;
	logic signed [64:0] pc_s2, pa_s2, pcv_s2, ppv_s2;
	logic cart_on_s2, ang_on_s2, eneg_s2, inr_s2, act_s2;
	logic [sfdc_pkg::TANH_X_W-1:0] x_s2;

	assign pc_d = e_s1 * cpg_q;
	assign pa_d = ea_s1 * pag_q;
	assign pcv_d = ncv_s1 * csg_q;
	assign ppv_d = npv_s1 * psg_q;
	assign mag_c = e_s1[32] ? 33'(33'd0 - e_s1) : e_s1;
	assign mag_a = ea_s1[32] ? 33'(33'd0 - ea_s1) : ea_s1;
	assign cart_on_d = mag_c > {2'b00, cdb_q};
	assign ang_on_d = mag_a >= {2'b00, adb_q};
	assign inr_d = mag_c < 33'd32768;
	assign x_d = {mag_c[14:0], 3'b000};

	always_ff @(posedge clk) begin
		if (en2) begin
			pc_s2 <= pc_d;
			pa_s2 <= pa_d;
			pcv_s2 <= pcv_d;
			ppv_s2 <= ppv_d;
			cart_on_s2 <= cart_on_d;
			ang_on_s2 <= ang_on_d;
			eneg_s2 <= e_s1[32];
			inr_s2 <= inr_d;
			x_s2 <= x_d;
			act_s2 <= act_s1;
		end
	end

	// Stage 3: floored products, deadzone offset and the tanh knot lookup.
	logic [sfdc_pkg::TANH_SCALED_W-1:0] scaled_d;
	logic [sfdc_pkg::TANH_IDX_W:0] idx0_d, idx1_d;
	logic [15:0] k0_d, k1_d;
	logic signed [16:0] dk_d;
	logic signed [48:0] pcf_d, angt_d, cvt_d, pvt_d;
	logic signed [49:0] s_d, suma_d;
	logic signed [49:0] s_s3, suma_s3;
	logic signed [48:0] pvt_s3;
	logic [15:0] k0_s3;
	logic signed [16:0] dk_s3;
	logic [sfdc_pkg::TANH_X_W-1:0] frac_s3;
	logic inr_s3, act_s3;

	assign scaled_d = sfdc_pkg::TANH_SCALED_W'(x_s2)
		* sfdc_pkg::TANH_SCALED_W'(sfdc_pkg::TANH_SEGMENTS);
	assign idx0_d = {1'b0, scaled_d[sfdc_pkg::TANH_X_W +: sfdc_pkg::TANH_IDX_W]};
	assign idx1_d = idx0_d + {{sfdc_pkg::TANH_IDX_W{1'b0}}, 1'b1};
	assign k0_d = sfdc_pkg::TANH_KNOTS[idx0_d];
	assign k1_d = sfdc_pkg::TANH_KNOTS[idx1_d];
	assign dk_d = $signed({1'b0, k1_d}) - $signed({1'b0, k0_d});

	assign pcf_d = $signed(pc_s2[64:16]);
	assign angt_d = ang_on_s2 ? $signed(pa_s2[64:16]) : 49'sd0;
	assign cvt_d = $signed(pcv_s2[64:16]);
	assign pvt_d = $signed(ppv_s2[64:16]);
	assign s_d = !cart_on_s2 ? 50'sd0
		: eneg_s2 ? ({pcf_d[48], pcf_d} - $signed({19'd0, dzo_q}))
		: ({pcf_d[48], pcf_d} + $signed({19'd0, dzo_q}));
	assign suma_d = {angt_d[48], angt_d} + {cvt_d[48], cvt_d};

	always_ff @(posedge clk) begin
		if (en3) begin
			s_s3 <= s_d;
			suma_s3 <= suma_d;
			pvt_s3 <= pvt_d;
			k0_s3 <= k0_d;
			dk_s3 <= dk_d;
			frac_s3 <= scaled_d[sfdc_pkg::TANH_X_W-1:0];
			inr_s3 <= inr_s2;
			act_s3 <= act_s2;
		end
	end

	// Stage 4: interpolation product and the sum of the linear terms.
	logic signed [35:0] tp_d;
	logic signed [50:0] sum3_d;
	logic signed [35:0] tp_s4;
	logic signed [50:0] sum3_s4;
	logic signed [49:0] s_s4;
	logic [15:0] k0_s4;
	logic inr_s4, act_s4;

	assign tp_d = dk_s3 * $signed({1'b0, frac_s3});
	assign sum3_d = {suma_s3[49], suma_s3} + {{2{pvt_s3[48]}}, pvt_s3};

	always_ff @(posedge clk) begin
		if (en4) begin
			tp_s4 <= tp_d;
			sum3_s4 <= sum3_d;
			s_s4 <= s_s3;
			k0_s4 <= k0_s3;
			inr_s4 <= inr_s3;
			act_s4 <= act_s3;
		end
	end

	// Stage 5: tanh value, truncating the interpolation toward zero.
	logic signed [35:0] tpr_d;
	logic signed [17:0] tq_d;
	logic [16:0] t_d;
	logic [16:0] t_s5;
	logic signed [49:0] s_s5;
	logic signed [50:0] sum3_s5;
	logic act_s5;

	assign tpr_d = tp_s4 + (tp_s4[35] ? 36'sd262143 : 36'sd0);
	assign tq_d = $signed(tpr_d[35:18]);
	assign t_d = inr_s4 ? 17'({1'b0, k0_s4} + tq_d[16:0])
		: {1'b0, sfdc_pkg::TANH_KNOTS[sfdc_pkg::TANH_SEGMENTS]};

	always_ff @(posedge clk) begin
		if (en5) begin
			t_s5 <= t_d;
			s_s5 <= s_s4;
			sum3_s5 <= sum3_s4;
			act_s5 <= act_s4;
		end
	end

	// Stage 6: cart term product.
	logic signed [66:0] st_d;
	logic signed [66:0] st_s6;
	logic signed [50:0] sum3_s6;
	logic act_s6;

	assign st_d = s_s5 * $signed(t_s5);

	always_ff @(posedge clk) begin
		if (en6) begin
			st_s6 <= st_d;
			sum3_s6 <= sum3_s5;
			act_s6 <= act_s5;
		end
	end

	// Stage 7: final sum, saturation and the output register.
	logic signed [50:0] ct_d;
	logic signed [52:0] total_d;
	logic signed [31:0] sat_d;
	sfdc_pkg::out_beat_t out_s7;

	assign ct_d = $signed(st_s6[66:16]);
	assign total_d = {{2{ct_d[50]}}, ct_d} + {{2{sum3_s6[50]}}, sum3_s6};
	assign sat_d = (total_d > 53'sd2147483647) ? 32'sh7fffffff
		: (total_d < -53'sd2147483648) ? 32'sh80000000
		: $signed(total_d[31:0]);

	always_ff @(posedge clk) begin
		if (en7) begin
			out_s7.drive_voltage <= act_s6 ? sat_d : 32'sd0;
			out_s7.active <= act_s6;
		end
	end

	assign out_valid = v_s7;
	assign out_data = out_s7;

	// A stall reaches the input only when every stage is full and the output waits.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7 && !out_ready))
		else $error("input stalled while the pipeline has room");

	a_tanh_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> !t_s5[16])
		else $error("tanh value out of range");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.active) |-> (out_data.drive_voltage == 32'sd0))
		else $error("nonzero drive outside the angle window");

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the state-feedback deadzone controller with a built-in predictor.
module tb;

	localparam logic [sfdc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int KNOTS = sfdc_pkg::TANH_SEGMENTS;
	localparam longint TANH_SPAN = 262144;
	localparam longint unsigned Q30 = 64'd1073741824;
	localparam int unsigned ANGLE_WIN_LO = 102943;
	localparam int unsigned ANGLE_WIN_HI = 308832;
	localparam int ITEMS_PER_PHASE = 56;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum {CFG_NOMINAL, CFG_TOP, CFG_BOTTOM, CFG_ZERO, CFG_SCATTER} cfg_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	sfdc_pkg::in_beat_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	sfdc_pkg::out_beat_t out_data;
	logic cfg_wr_en = 1'b0;
	logic [sfdc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	longint k_cart_pos = 29309;
	longint k_pend_ang = 1319341;
	longint k_cart_spd = 3815;
	longint k_pend_spd = -34709;
	longint dz_offset = 49152;
	longint cart_db = 13107;
	longint ang_db = 3431;

	longint tanh_lut [KNOTS+1];
	sfdc_pkg::in_beat_t sample_q [$];
	sfdc_pkg::out_beat_t due_drive_q [$];
	int send_idle_pct = 0;
	int stall_pct = 0;
	int fault_count = 0;
	int cycle_count = 0;

	state_feedback_deadzone_controller u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint knot_value(longint unsigned i);
		longint unsigned x, b, b2, b3, b4, y, num, den, r;
		x = (i * TANH_SPAN) / KNOTS;
		b = ((2 * x) << 14) >> 8;
		b2 = (b * b) >> 30;
		b3 = (b2 * b) >> 30;
		b4 = (b3 * b) >> 30;
		y = Q30 - b + b2 / 2 - b3 / 6 + b4 / 24;
		if (y > Q30) begin
			y = Q30;
		end
		for (int k = 0; k < 8; k++) begin
			y = (y * y) >> 30;
		end
		num = (Q30 - y) << 16;
		den = Q30 + y;
		r = (num + den / 2) / den;
		if (r > 65535) begin
			r = 65535;
		end
		return longint'(r);
	endfunction

	function automatic longint tanh_pwl(longint unsigned x);
		longint unsigned scaled, idx, frac;
		if (x >= TANH_SPAN) begin
			return tanh_lut[KNOTS];
		end
		scaled = x * KNOTS;
		idx = scaled / TANH_SPAN;
		frac = scaled - idx * TANH_SPAN;
		return tanh_lut[idx] + (tanh_lut[idx+1] - tanh_lut[idx]) * longint'(frac) / TANH_SPAN;
	endfunction

	function automatic sfdc_pkg::out_beat_t feedback_law(sfdc_pkg::in_beat_t b);
		longint e, ea, s, t, cart_term, ang_term, sum;
		longint unsigned mag;
		sfdc_pkg::out_beat_t r;
		r = '0;
		if (!(b.reduced_angle > ANGLE_WIN_LO && b.reduced_angle < ANGLE_WIN_HI)) begin
			return r;
		end
		cart_term = 0;
		ang_term = 0;
		e = longint'($signed(b.cart_target)) - longint'($signed(b.cart_pos));
		if (e > cart_db || e < -cart_db) begin
			mag = (e < 0) ? -e : e;
			t = tanh_pwl(8 * mag);
			s = (k_cart_pos * e) >>> 16;
			s += (e > 0) ? dz_offset : -dz_offset;
			cart_term = (s * t) >>> 16;
		end
		ea = longint'($signed(b.angle_target)) - longint'($signed(b.pend_ang));
		if (!(ea < ang_db && ea > -ang_db)) begin
			ang_term = (k_pend_ang * ea) >>> 16;
		end
		sum = cart_term + ang_term
			+ ((k_cart_spd * -longint'($signed(b.cart_vel))) >>> 16)
			+ ((k_pend_spd * -longint'($signed(b.pend_vel))) >>> 16);
		if (sum > 64'sd2147483647) begin
			sum = 64'sd2147483647;
		end
		if (sum < -64'sd2147483648) begin
			sum = -64'sd2147483648;
		end
		r.drive_voltage = sum[31:0];
		r.active = 1'b1;
		return r;
	endfunction

	function automatic logic [31:0] error_offset(longint db);
		logic [31:0] mag;
		case ($urandom_range(4))
			0: mag = $urandom_range(3);
			1: mag = 32'(db) + $urandom_range(4) - 2;
			2: mag = $urandom_range(40000);
			3: mag = $urandom_range(1 << 20);
			default: return $urandom;
		endcase
		return $urandom_range(1) ? -mag : mag;
	endfunction

	function automatic logic [31:0] speed_value();
		return $urandom_range(1) ? $urandom : 32'($urandom_range(1 << 18)) - 32'd131072;
	endfunction

	function automatic sfdc_pkg::in_beat_t random_sample();
		sfdc_pkg::in_beat_t s;
		s.cart_pos = $urandom_range(1) ? $urandom : 32'($urandom_range(1 << 22)) - 32'h200000;
		s.cart_target = s.cart_pos + error_offset(cart_db);
		s.pend_ang = $urandom_range(1) ? $urandom : 32'($urandom_range(1 << 20)) - 32'h80000;
		s.angle_target = s.pend_ang + error_offset(ang_db);
		s.cart_vel = speed_value();
		s.pend_vel = speed_value();
		if ($urandom_range(9) < 8) begin
			s.reduced_angle = 19'($urandom_range(ANGLE_WIN_HI - 1, ANGLE_WIN_LO + 1));
		end else begin
			s.reduced_angle = 19'($urandom_range(19'h7FFFF));
		end
		return s;
	endfunction

	task automatic reg_write(input logic [sfdc_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			sfdc_pkg::REG_CART_POS_GAIN: k_cart_pos = longint'($signed(val));
			sfdc_pkg::REG_PEND_ANG_GAIN: k_pend_ang = longint'($signed(val));
			sfdc_pkg::REG_CART_SPD_GAIN: k_cart_spd = longint'($signed(val));
			sfdc_pkg::REG_PEND_SPD_GAIN: k_pend_spd = longint'($signed(val));
			sfdc_pkg::REG_DEADZONE_OFS: dz_offset = longint'({1'b0, val[30:0]});
			sfdc_pkg::REG_CART_DEADBAND: cart_db = longint'({1'b0, val[30:0]});
			sfdc_pkg::REG_ANGLE_DEADBAND: ang_db = longint'({1'b0, val[30:0]});
			default: ;
		endcase
	endtask

	task automatic program_regs(input cfg_kind_t kind);
		logic [31:0] pg, ag, sg, vg, ofs, cdb, adb;
		case (kind)
			CFG_NOMINAL: begin
				pg = 32'($urandom_range(1 << 20)) - 32'h80000;
				ag = 32'($urandom_range(1 << 23)) - 32'h400000;
				sg = 32'($urandom_range(1 << 15)) - 32'h4000;
				vg = 32'($urandom_range(1 << 18)) - 32'h20000;
				ofs = {1'($urandom_range(1)), 31'($urandom_range(1 << 17))};
				cdb = {1'($urandom_range(1)), 31'($urandom_range(1 << 15))};
				adb = {1'($urandom_range(1)), 31'($urandom_range(1 << 13))};
			end
			CFG_TOP: begin
				pg = 32'h7FFFFFFF;
				ag = 32'h7FFFFFFF;
				sg = 32'h7FFFFFFF;
				vg = 32'h7FFFFFFF;
				ofs = 32'hFFFFFFFF;
				cdb = 32'h80000000;
				adb = 32'h80000000;
			end
			CFG_BOTTOM: begin
				pg = 32'h80000000;
				ag = 32'h80000000;
				sg = 32'h80000000;
				vg = 32'h80000000;
				ofs = 32'h0;
				cdb = 32'h7FFFFFFF;
				adb = 32'h7FFFFFFF;
			end
			CFG_ZERO: begin
				pg = '0;
				ag = '0;
				sg = '0;
				vg = '0;
				ofs = 32'h7FFFFFFF;
				cdb = '0;
				adb = '0;
			end
			default: begin
				pg = $urandom;
				ag = $urandom;
				sg = $urandom;
				vg = $urandom;
				ofs = $urandom;
				cdb = $urandom;
				adb = $urandom;
			end
		endcase
		reg_write(sfdc_pkg::REG_CART_POS_GAIN, pg);
		reg_write(sfdc_pkg::REG_PEND_ANG_GAIN, ag);
		reg_write(sfdc_pkg::REG_CART_SPD_GAIN, sg);
		reg_write(sfdc_pkg::REG_PEND_SPD_GAIN, vg);
		reg_write(sfdc_pkg::REG_DEADZONE_OFS, ofs);
		reg_write(sfdc_pkg::REG_CART_DEADBAND, cdb);
		reg_write(sfdc_pkg::REG_ANGLE_DEADBAND, adb);
		reg_write(REG_UNUSED, $urandom);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (sample_q.size() != 0 || in_valid || due_drive_q.size() != 0);
	endtask

	// Driver: a new beat is offered only once the current one has been taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				due_drive_q.push_back(feedback_law(in_data));
			end
			if (!in_valid || in_ready) begin
				if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= sample_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		sfdc_pkg::out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_drive_q.size() == 0) begin
				$display("%0t: drive beat with none pending, expected none, got %0d active %0b",
					$time, out_data.drive_voltage, out_data.active);
				fault_count++;
			end else begin
				want = due_drive_q.pop_front();
				if (out_data.drive_voltage !== want.drive_voltage) begin
					$display("%0t: drive_voltage expected %0d got %0d",
						$time, want.drive_voltage, out_data.drive_voltage);
					fault_count++;
				end
				if (out_data.active !== want.active) begin
					$display("%0t: active expected %0b got %0b",
						$time, want.active, out_data.active);
					fault_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		sfdc_pkg::in_beat_t s;
		logic [18:0] rim [6];
		logic [31:0] cart_err [8];
		logic [31:0] ang_err [4];
		cfg_kind_t plan [8];
		int send_mode [4];
		int stall_mode [4];
		rim = '{19'(ANGLE_WIN_LO), 19'(ANGLE_WIN_LO + 1), 19'(ANGLE_WIN_HI - 1),
			19'(ANGLE_WIN_HI), 19'd411775, 19'h7FFFF};
		cart_err = '{32'(cart_db), 32'(cart_db + 1), 32'(-cart_db), 32'(-cart_db - 1),
			32'd32767, 32'd32768, 32'd40000, -32'd32768};
		ang_err = '{32'(ang_db), 32'(ang_db - 1), 32'(-ang_db), 32'(-(ang_db - 1))};
		plan = '{CFG_NOMINAL, CFG_TOP, CFG_NOMINAL, CFG_BOTTOM,
			CFG_SCATTER, CFG_NOMINAL, CFG_ZERO, CFG_SCATTER};
		send_mode = '{0, 61, 0, 13};
		stall_mode = '{0, 0, 61, 13};
		for (int i = 0; i <= KNOTS; i++) begin
			tanh_lut[i] = knot_value(i);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		sample_q.push_back('0);
		s = '0;
		s.cart_vel = 32'sd655360;
		s.cart_target = 32'sd100000;
		s.angle_target = 32'sd20000;
		for (int k = 0; k < 6; k++) begin
			s.reduced_angle = rim[k];
			sample_q.push_back(s);
		end
		s = '0;
		s.reduced_angle = 19'd205887;
		for (int k = 0; k < 8; k++) begin
			s.cart_target = cart_err[k];
			sample_q.push_back(s);
		end
		s.cart_target = '0;
		for (int k = 0; k < 4; k++) begin
			s.angle_target = ang_err[k];
			sample_q.push_back(s);
		end
		s.pend_ang = 32'h80000000;
		s.angle_target = 32'h7FFFFFFF;
		sample_q.push_back(s);
		s.pend_ang = 32'h7FFFFFFF;
		s.angle_target = 32'h80000000;
		sample_q.push_back(s);
		s.cart_pos = 32'h7FFFFFFF;
		s.cart_vel = 32'h7FFFFFFF;
		s.pend_ang = 32'h7FFFFFFF;
		s.pend_vel = 32'h7FFFFFFF;
		s.reduced_angle = 19'(ANGLE_WIN_HI - 1);
		s.cart_target = 32'h7FFFFFFF;
		s.angle_target = 32'h7FFFFFFF;
		sample_q.push_back(s);
		s.cart_pos = 32'h80000000;
		s.cart_vel = 32'h80000000;
		s.pend_ang = 32'h80000000;
		s.pend_vel = 32'h80000000;
		s.reduced_angle = 19'(ANGLE_WIN_LO + 1);
		s.cart_target = 32'h80000000;
		s.angle_target = 32'h80000000;
		sample_q.push_back(s);
		s = '0;
		s.reduced_angle = 19'd205887;
		s.cart_vel = 32'h80000000;
		s.pend_vel = 32'h80000000;
		sample_q.push_back(s);

		for (int p = 0; p < 8; p++) begin
			wait_drained();
			program_regs(plan[p]);
			send_idle_pct = send_mode[(p + 1) % 4];
			stall_pct = stall_mode[(p + 1) % 4];
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				sample_q.push_back(random_sample());
			end
		end

		wait_drained();
		repeat (12) @(posedge clk);
		if (fault_count == 0 && due_drive_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
